@@ hw/rtl/psce_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package psce_pkg;

  localparam int DATA_W        = 32;
  localparam int P_W           = 6;
  localparam int IDX_W         = 7;
  localparam int OP_W          = 3;
  localparam int ST_W          = 2;
  localparam int FRAC_W        = 24;
  localparam int PROD_W        = 64;
  localparam int RND_W         = 40;
  localparam int ACC_W         = 48;
  localparam int DIV_W         = 57;
  localparam int DEN_W         = 32;
  localparam int DIV_CNT_W     = 6;
  localparam int KQ_W          = 34;
  localparam int STEP_W        = 3;
  localparam int IN_TDATA_W    = 168;
  localparam int OUT_TDATA_W   = 32;
  localparam int DEF_MAX_TERMS = 64;

  localparam logic [OP_W-1:0] OP_WR_A    = 3'd0;
  localparam logic [OP_W-1:0] OP_WR_B    = 3'd1;
  localparam logic [OP_W-1:0] OP_PRODUCT = 3'd2;
  localparam logic [OP_W-1:0] OP_DIVIDE  = 3'd3;
  localparam logic [OP_W-1:0] OP_POWER   = 3'd4;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_SAT  = 2'd1;
  localparam logic [ST_W-1:0] ST_DIV0 = 2'd2;

  typedef enum logic [3:0] {
    SRC_VALUE, SRC_ZA, SRC_ZB, SRC_GA, SRC_GB, SRC_T, SRC_ACC, SRC_A, SRC_B, SRC_Q
  } src_t;

  typedef enum logic [1:0] {BIX_P, BIX_P1, BIX_ONE} bix_t;

  typedef enum logic [1:0] {DST_T, DST_LOAD, DST_ADD} dst_t;

  typedef struct packed {
    src_t x;
    src_t y;
    bix_t bix;
    dst_t dst;
    logic last;
  } step_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_LOOP, S_DRAIN, S_SC_ADDR, S_SC_WAIT, S_SC_MUL, S_SC_APPLY,
    S_PREDIV, S_PREDIV_WAIT, S_PREP, S_DIV_START, S_DIV_WAIT, S_FINISH
  } state_t;

  typedef struct packed {
    logic            latch;
    logic            store_write;
    logic            sc_addr;
    logic            sc_mul;
    logic            sc_apply;
    step_t           step;
    logic            issue;
    logic [P_W-1:0]  loop_i;
    logic            prediv_start;
    logic            kinit;
    logic            prep;
    logic            div_start;
    logic            finish;
  } psce_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [P_W-1:0]  p;
    logic            pipe_busy;
    logic            div_busy;
    logic            den_zero;
    logic            out_busy;
  } psce_stat_t;

  // scalar multiply program for each operation
  function automatic step_t step_prog(input logic [OP_W-1:0] op,
                                      input logic [STEP_W-1:0] idx);
    step_t s;
    s = '{x: SRC_VALUE, y: SRC_VALUE, bix: BIX_P, dst: DST_T, last: 1'b1};
    case (op)
      OP_PRODUCT: begin
        case (idx)
          3'd0: s = '{x: SRC_ACC, y: SRC_GA, bix: BIX_P, dst: DST_T,    last: 1'b0};
          3'd1: s = '{x: SRC_T,   y: SRC_GB, bix: BIX_P, dst: DST_LOAD, last: 1'b0};
          3'd2: s = '{x: SRC_ZB,  y: SRC_A,  bix: BIX_P, dst: DST_T,    last: 1'b0};
          3'd3: s = '{x: SRC_T,   y: SRC_GA, bix: BIX_P, dst: DST_ADD,  last: 1'b0};
          3'd4: s = '{x: SRC_ZA,  y: SRC_B,  bix: BIX_P, dst: DST_T,    last: 1'b0};
          default: s = '{x: SRC_T, y: SRC_GB, bix: BIX_P, dst: DST_ADD, last: 1'b1};
        endcase
      end
      OP_DIVIDE: begin
        case (idx)
          3'd0: s = '{x: SRC_ZA, y: SRC_B, bix: BIX_P1, dst: DST_LOAD, last: 1'b0};
          default: s = '{x: SRC_B, y: SRC_Q, bix: BIX_ONE, dst: DST_ADD, last: 1'b1};
        endcase
      end
      OP_POWER: begin
        case (idx)
          3'd0: s = '{x: SRC_VALUE, y: SRC_A, bix: BIX_P, dst: DST_T, last: 1'b0};
          default: s = '{x: SRC_T, y: SRC_ZB, bix: BIX_P, dst: DST_LOAD, last: 1'b1};
        endcase
      end
      default: s = '{x: SRC_VALUE, y: SRC_VALUE, bix: BIX_P, dst: DST_T, last: 1'b1};
    endcase
    return s;
  endfunction

  // x*y/2^24, rounded to nearest, ties away from zero
  function automatic logic signed [RND_W-1:0] rnd_q(input logic signed [PROD_W-1:0] pr);
    logic [PROD_W-1:0] m;
    logic [PROD_W-1:0] r;
    m = pr[PROD_W-1] ? PROD_W'(-pr) : PROD_W'(pr);
    r = (m + (PROD_W'(1) << (FRAC_W - 1))) >> FRAC_W;
    return pr[PROD_W-1] ? -$signed(r[RND_W-1:0]) : $signed(r[RND_W-1:0]);
  endfunction

  function automatic logic ovf32(input logic signed [ACC_W-1:0] x);
    return !((&x[ACC_W-1:DATA_W-1]) || !(|x[ACC_W-1:DATA_W-1]));
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    r = x[DATA_W-1:0];
    if (ovf32(x))
      r = x[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/psce_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module psce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hw/rtl/psce_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module psce_div import psce_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic                  busy,
  output logic      [DIV_W-1:0] quotient,
  output logic      [DEN_W-1:0] remainder
);

  logic [DIV_W-1:0]     quo_r;
  logic [DEN_W-1:0]     rem_r;
  logic [DEN_W-1:0]     den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic [DEN_W:0]       trial;
  logic                 ge;
  logic [DEN_W:0]       diff;

  // restoring division, one quotient bit a cycle
  always_comb begin
    trial = {rem_r, quo_r[DIV_W-1]};
    ge    = trial >= {1'b0, den_r};
    diff  = trial - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(DIV_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], ge};
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

@@ hw/rtl/psce_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module psce_datapath import psce_pkg::*; #(
  parameter int MAX_TERMS = DEF_MAX_TERMS
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire psce_cmd_t                cmd,
  output psce_stat_t                    stat,
  input  wire logic [OP_W-1:0]          in_operation,
  input  wire logic [P_W-1:0]           in_term_index,
  input  wire logic signed [DATA_W-1:0] in_value,
  input  wire logic signed [DATA_W-1:0] in_zero_a,
  input  wire logic signed [DATA_W-1:0] in_zero_b,
  input  wire logic signed [DATA_W-1:0] in_gain_a,
  input  wire logic signed [DATA_W-1:0] in_gain_b,
  input  wire logic                     out_ready,
  output logic                          out_valid,
  output logic signed [DATA_W-1:0]      out_result,
  output logic [ST_W-1:0]               out_status
);

  localparam int AW = $clog2(MAX_TERMS);
  localparam logic signed [DATA_W:0] ONE33 = 33'sd16777216;
  localparam logic signed [KQ_W+1:0] ONE_K = (KQ_W+2)'(16777216);

  function automatic logic in_rng(input logic [IDX_W-1:0] idx);
    return {{(32-IDX_W){1'b0}}, idx} < 32'(MAX_TERMS);
  endfunction

  // latched item
  logic [OP_W-1:0]          op_r;
  logic [P_W-1:0]           p_r;
  logic signed [DATA_W-1:0] value_r, za_r, zb_r, ga_r, gb_r;

  logic signed [ACC_W-1:0]  acc_r;
  logic signed [RND_W-1:0]  t_r;
  logic                     clamp_r;

  logic [IDX_W-1:0] a_idx_r, b_idx_r, q_idx_r;
  logic             a_in_r, b_in_r, q_in_r;
  logic             a_in_d, b_in_d, q_in_d;
  logic [DATA_W-1:0] a_dout, b_dout, q_dout;
  logic signed [DATA_W-1:0] a_opd, b_opd, q_opd;

  // loop pipeline
  logic [4:0]               pipe_v;
  logic [KQ_W-1:0]          kq_s0;
  logic signed [DATA_W-1:0] k_s1, k_s2, k_s3;
  logic signed [PROD_W-1:0] prod1_r, prod2_r;
  logic signed [RND_W-1:0]  m1_r, m4_r;

  // weights of the power loop
  logic [KQ_W-1:0] qv_r, kq_r;
  logic [P_W-1:0]  rv_r, kr_r;
  logic [P_W:0]    tr;
  logic            tr_ge;
  logic [KQ_W-1:0] kq_next;
  logic [P_W-1:0]  kr_next;
  logic signed [DATA_W:0] v_ext;
  logic            vneg;
  logic [DATA_W:0] vmag;
  logic signed [KQ_W+1:0] kfull;
  logic signed [ACC_W-1:0] kfull_x;

  // division operands
  logic              num_neg_r, den_neg_r, den_zero_r;
  logic [DATA_W-1:0] num_mag_r;
  logic [DEN_W-1:0]  den_mag_r;
  logic signed [DATA_W+1:0] num_w;
  logic [DATA_W+1:0] num_abs;
  logic [DATA_W-1:0] den_sel;

  logic             div_start;
  logic [DIV_W-1:0] div_n;
  logic [DEN_W-1:0] div_d;
  logic             div_busy;
  logic [DIV_W-1:0] div_quo;
  logic [DEN_W-1:0] div_rem;

  logic signed [ACC_W-1:0]  t_x;
  logic signed [DATA_W-1:0] sat_t, sat_acc;
  logic signed [DATA_W-1:0] sx, sy, lx, ly, mx, my;
  logic                     sc_ovf;
  logic signed [RND_W-1:0]  rnd1, rnd2;
  logic signed [ACC_W-1:0]  rnd1_x, m1_x;
  logic signed [DATA_W-1:0] m1_sat;
  logic signed [RND_W-1:0]  m1_next;
  logic signed [RND_W-1:0]  term;
  logic                     is_pow, is_div;
  logic [IDX_W-1:0]         p_x, p1_x, i_x;

  logic signed [DATA_W-1:0] fin_res;
  logic                     fin_ovf;
  logic [ST_W-1:0]          fin_st;
  logic                     q_big;

  logic             we_a, we_b, we_q;
  logic [DATA_W-1:0] wdata_b;

  assign is_pow = op_r == OP_POWER;
  assign is_div = op_r == OP_DIVIDE;
  assign p_x    = {1'b0, p_r};
  assign p1_x   = p_x + 1'b1;
  assign i_x    = {1'b0, cmd.loop_i};

  assign a_opd = a_in_d ? $signed(a_dout) : '0;
  assign b_opd = b_in_d ? $signed(b_dout) : '0;
  assign q_opd = q_in_d ? $signed(q_dout) : '0;

  assign t_x     = {{(ACC_W-RND_W){t_r[RND_W-1]}}, t_r};
  assign sat_t   = sat32(t_x);
  assign sat_acc = sat32(acc_r);

  function automatic logic signed [DATA_W-1:0] pick(input src_t s,
      input logic signed [DATA_W-1:0] v, za, zb, ga, gb, st, sa, a, b, q);
    logic signed [DATA_W-1:0] r;
    case (s)
      SRC_VALUE: r = v;
      SRC_ZA:    r = za;
      SRC_ZB:    r = zb;
      SRC_GA:    r = ga;
      SRC_GB:    r = gb;
      SRC_T:     r = st;
      SRC_ACC:   r = sa;
      SRC_A:     r = a;
      SRC_B:     r = b;
      SRC_Q:     r = q;
      default:   r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    sx = pick(cmd.step.x, value_r, za_r, zb_r, ga_r, gb_r, sat_t, sat_acc, a_opd, b_opd, q_opd);
    sy = pick(cmd.step.y, value_r, za_r, zb_r, ga_r, gb_r, sat_t, sat_acc, a_opd, b_opd, q_opd);
    sc_ovf = ((cmd.step.x == SRC_T || cmd.step.y == SRC_T) && ovf32(t_x)) ||
             ((cmd.step.x == SRC_ACC || cmd.step.y == SRC_ACC) && ovf32(acc_r));
    lx = is_div ? q_opd : a_opd;
    ly = b_opd;
    mx = cmd.sc_mul ? sx : lx;
    my = cmd.sc_mul ? sy : ly;
  end

  always_comb begin
    rnd1    = rnd_q(prod1_r);
    rnd2    = rnd_q(prod2_r);
    rnd1_x  = {{(ACC_W-RND_W){rnd1[RND_W-1]}}, rnd1};
    m1_sat  = sat32(rnd1_x);
    m1_x    = {{(ACC_W-DATA_W){m1_sat[DATA_W-1]}}, m1_sat};
    m1_next = is_pow ? m1_x[RND_W-1:0] : rnd1;
    term    = is_pow ? rnd2 : m4_r;
  end

  // (value + 1) * i / p rounded, stepped with quotient and remainder of |value + 1| / p
  always_comb begin
    v_ext   = {value_r[DATA_W-1], value_r} + ONE33;
    vneg    = v_ext[DATA_W];
    vmag    = vneg ? DATA_W'(0) - v_ext : v_ext;
    tr      = {1'b0, kr_r} + {1'b0, rv_r};
    tr_ge   = tr >= {1'b0, p_r};
    kq_next = kq_r + qv_r + KQ_W'(tr_ge);
    kr_next = tr_ge ? P_W'(tr - {1'b0, p_r}) : tr[P_W-1:0];
    kfull   = (vneg ? -$signed({2'b00, kq_s0}) : $signed({2'b00, kq_s0})) - ONE_K;
    kfull_x = {{(ACC_W-KQ_W-2){kfull[KQ_W+1]}}, kfull};
  end

  always_comb begin
    if (is_div) begin
      num_w = {{2{value_r[DATA_W-1]}}, value_r} - {{2{sat_acc[DATA_W-1]}}, sat_acc};
    end else begin
      num_w = {{2{sat_acc[DATA_W-1]}}, sat_acc};
    end
    num_abs = num_w[DATA_W+1] ? DATA_W'(0) - num_w : num_w;
    den_sel = is_div ? zb_r : za_r;
  end

  always_comb begin
    div_start = cmd.prediv_start || cmd.div_start;
    if (cmd.prediv_start) begin
      div_n = DIV_W'(vmag);
      div_d = DEN_W'(p_r);
    end else begin
      div_n = DIV_W'({num_mag_r, {FRAC_W{1'b0}}}) + DIV_W'(den_mag_r >> 1);
      div_d = den_mag_r;
    end
  end

  psce_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_n),
    .divisor   (div_d),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    fin_res = '0;
    fin_ovf = 1'b0;
    q_big   = 1'b0;
    if (op_r == OP_PRODUCT) begin
      fin_res = sat_acc;
      fin_ovf = ovf32(acc_r);
    end else if (!den_zero_r) begin
      if (num_neg_r ^ den_neg_r) begin
        q_big   = div_quo > DIV_W'(64'd2147483648);
        fin_res = q_big ? {1'b1, {(DATA_W-1){1'b0}}} : -$signed(div_quo[DATA_W-1:0]);
      end else begin
        q_big   = div_quo > DIV_W'(64'd2147483647);
        fin_res = q_big ? {1'b0, {(DATA_W-1){1'b1}}} : $signed(div_quo[DATA_W-1:0]);
      end
      fin_ovf = q_big;
    end
    if (op_r != OP_PRODUCT && den_zero_r) begin
      fin_st = ST_DIV0;
    end else if (clamp_r || fin_ovf) begin
      fin_st = ST_SAT;
    end else begin
      fin_st = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= in_operation;
      p_r     <= in_term_index;
      value_r <= in_value;
      za_r    <= in_zero_a;
      zb_r    <= in_zero_b;
      ga_r    <= in_gain_a;
      gb_r    <= in_gain_b;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      acc_r <= '0;
    end else if (cmd.sc_apply && cmd.step.dst == DST_LOAD) begin
      acc_r <= rnd1_x;
    end else if (cmd.sc_apply && cmd.step.dst == DST_ADD) begin
      acc_r <= acc_r + rnd1_x;
    end else if (pipe_v[4]) begin
      acc_r <= acc_r + {{(ACC_W-RND_W){term[RND_W-1]}}, term};
    end
    if (cmd.sc_apply && cmd.step.dst == DST_T) begin
      t_r <= rnd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      clamp_r <= 1'b0;
    end else begin
      clamp_r <= clamp_r
               | (cmd.sc_mul && sc_ovf)
               | (pipe_v[0] && is_pow && ovf32(kfull_x))
               | (pipe_v[2] && is_pow && ovf32(rnd1_x))
               | (cmd.prep && ovf32(acc_r));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sc_addr) begin
      a_idx_r <= p_x;
      q_idx_r <= p_x;
      a_in_r  <= in_rng(p_x);
      q_in_r  <= in_rng(p_x);
      case (cmd.step.bix)
        BIX_P1: begin
          b_idx_r <= p1_x;
          b_in_r  <= in_rng(p1_x);
        end
        BIX_ONE: begin
          b_idx_r <= IDX_W'(1);
          b_in_r  <= in_rng(IDX_W'(1));
        end
        default: begin
          b_idx_r <= p_x;
          b_in_r  <= in_rng(p_x);
        end
      endcase
    end else if (cmd.issue) begin
      a_idx_r <= i_x;
      q_idx_r <= i_x;
      a_in_r  <= in_rng(i_x);
      q_in_r  <= in_rng(i_x);
      b_idx_r <= is_div ? p1_x - i_x : p_x - i_x;
      b_in_r  <= in_rng(is_div ? p1_x - i_x : p_x - i_x);
    end
    a_in_d <= a_in_r;
    b_in_d <= b_in_r;
    q_in_d <= q_in_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_v <= '0;
    end else begin
      pipe_v <= {pipe_v[3:0], cmd.issue};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sc_mul || pipe_v[1]) begin
      prod1_r <= mx * my;
    end
    if (pipe_v[2]) begin
      m1_r <= m1_next;
    end
    if (pipe_v[3]) begin
      prod2_r <= k_s3 * $signed(m1_r[DATA_W-1:0]);
      m4_r    <= m1_r;
    end
    kq_s0 <= kq_next;
    k_s1  <= sat32(kfull_x);
    k_s2  <= k_s1;
    k_s3  <= k_s2;
    if (cmd.kinit) begin
      qv_r <= div_quo[KQ_W-1:0];
      rv_r <= div_rem[P_W-1:0];
      kq_r <= '0;
      kr_r <= p_r >> 1;
    end else if (cmd.issue) begin
      kq_r <= kq_next;
      kr_r <= kr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      num_neg_r  <= num_w[DATA_W+1];
      num_mag_r  <= num_abs[DATA_W-1:0];
      den_neg_r  <= den_sel[DATA_W-1];
      den_mag_r  <= den_sel[DATA_W-1] ? DEN_W'(0) - den_sel : den_sel;
      den_zero_r <= den_sel == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_result <= fin_res;
      out_status <= fin_st;
    end
  end

  always_comb begin
    we_a    = cmd.store_write && op_r == OP_WR_A && in_rng(p_x);
    we_b    = (cmd.store_write && op_r == OP_WR_B && in_rng(p_x)) ||
              (cmd.finish && is_pow && !den_zero_r && in_rng(p_x));
    we_q    = cmd.finish && is_div && !den_zero_r && in_rng(p1_x);
    wdata_b = cmd.store_write ? value_r : fin_res;
  end

  psce_ram #(.WIDTH(DATA_W), .DEPTH(MAX_TERMS)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (AW'(p_x)),
    .wdata (value_r),
    .raddr (AW'(a_idx_r)),
    .rdata (a_dout)
  );

  psce_ram #(.WIDTH(DATA_W), .DEPTH(MAX_TERMS)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (AW'(p_x)),
    .wdata (wdata_b),
    .raddr (AW'(b_idx_r)),
    .rdata (b_dout)
  );

  psce_ram #(.WIDTH(DATA_W), .DEPTH(MAX_TERMS)) u_ram_q (
    .clk   (clk),
    .we    (we_q),
    .waddr (AW'(p1_x)),
    .wdata (fin_res),
    .raddr (AW'(q_idx_r)),
    .rdata (q_dout)
  );

  always_comb begin
    stat.op        = op_r;
    stat.p         = p_r;
    stat.pipe_busy = |pipe_v;
    stat.div_busy  = div_busy;
    stat.den_zero  = den_zero_r;
    stat.out_busy  = out_valid && !out_ready;
  end

endmodule
`default_nettype wire

@@ hw/rtl/psce_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module psce_ctrl import psce_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire psce_stat_t stat,
  output psce_cmd_t       cmd
);

  state_t            state_r, state_next;
  logic [STEP_W-1:0] step_r;
  logic [P_W-1:0]    i_r;
  step_t             st;
  logic              p_ge2;

  assign st    = step_prog(stat.op, step_r);
  assign p_ge2 = stat.p >= P_W'(2);

  always_comb begin
    state_next = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_PRODUCT: state_next = p_ge2 ? S_LOOP : S_SC_ADDR;
          OP_DIVIDE:  state_next = S_SC_ADDR;
          OP_POWER:   state_next = S_SC_ADDR;
          default:    state_next = S_IDLE;
        endcase
      end
      S_LOOP: begin
        if (i_r == stat.p - 1'b1) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) state_next = (stat.op == OP_PRODUCT) ? S_SC_ADDR : S_PREP;
      end
      S_SC_ADDR: state_next = S_SC_WAIT;
      S_SC_WAIT: state_next = S_SC_MUL;
      S_SC_MUL:  state_next = S_SC_APPLY;
      S_SC_APPLY: begin
        if (!st.last) begin
          state_next = S_SC_ADDR;
        end else if (stat.op == OP_PRODUCT) begin
          state_next = S_FINISH;
        end else if (stat.op == OP_DIVIDE) begin
          state_next = p_ge2 ? S_LOOP : S_PREP;
        end else begin
          state_next = p_ge2 ? S_PREDIV : S_PREP;
        end
      end
      S_PREDIV: state_next = S_PREDIV_WAIT;
      S_PREDIV_WAIT: begin
        if (!stat.div_busy) state_next = S_LOOP;
      end
      S_PREP: state_next = S_DIV_START;
      S_DIV_START: state_next = stat.den_zero ? S_FINISH : S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (!stat.div_busy) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.step   = st;
    cmd.loop_i = i_r;
    in_ready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_DISPATCH:    cmd.store_write  = stat.op == OP_WR_A || stat.op == OP_WR_B;
      S_LOOP:        cmd.issue        = 1'b1;
      S_SC_ADDR:     cmd.sc_addr      = 1'b1;
      S_SC_MUL:      cmd.sc_mul       = 1'b1;
      S_SC_APPLY:    cmd.sc_apply     = 1'b1;
      S_PREDIV:      cmd.prediv_start = 1'b1;
      S_PREDIV_WAIT: cmd.kinit        = !stat.div_busy;
      S_PREP:        cmd.prep         = 1'b1;
      S_DIV_START:   cmd.div_start    = !stat.den_zero;
      S_FINISH:      cmd.finish       = !stat.out_busy;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      i_r     <= P_W'(1);
    end else begin
      state_r <= state_next;
      if (state_r == S_DISPATCH) begin
        step_r <= '0;
      end else if (state_r == S_SC_APPLY && !st.last) begin
        step_r <= step_r + 1'b1;
      end
      i_r <= (state_r == S_LOOP) ? i_r + 1'b1 : P_W'(1);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/power_series_coefficient_engine_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One item at a time (p = term order); the single multiply-accumulate pipe
// walks the p-1 term pairs one a cycle, and divide and power finish on the
// bit-serial divider. A finished result waits in the output register while
// the next beat is taken. rst is synchronous; it clears control state only,
// the coefficient stores are undefined until written.
module power_series_coefficient_engine_core import psce_pkg::*; #(
  parameter int MAX_TERMS = DEF_MAX_TERMS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // term_index[5:0], value[37:6], zero_a[69:38], zero_b[101:70], gain_a[133:102],
  // gain_b[165:134], zero fill
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  // operation[2:0]
  input  wire logic [OP_W-1:0]        s_tuser,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // result[31:0]
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  // status[1:0]
  output logic [ST_W-1:0]             m_tuser
);

  psce_cmd_t  cmd;
  psce_stat_t stat;
  logic signed [DATA_W-1:0] result;

  psce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  psce_datapath #(.MAX_TERMS(MAX_TERMS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_operation  (s_tuser),
    .in_term_index (s_tdata[5:0]),
    .in_value      (s_tdata[37:6]),
    .in_zero_a     (s_tdata[69:38]),
    .in_zero_b     (s_tdata[101:70]),
    .in_gain_a     (s_tdata[133:102]),
    .in_gain_b     (s_tdata[165:134]),
    .out_ready     (m_tready),
    .out_valid     (m_tvalid),
    .out_result    (result),
    .out_status    (m_tuser)
  );

  assign m_tdata = result;

endmodule
`default_nettype wire

@@ bench/power_series_coefficient_checker.sv @@
`timescale 1ns / 1ps
module power_series_coefficient_checker import psce_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  input  wire logic                  s_tready,
  input  wire logic [IN_TDATA_W-1:0] s_tdata,
  input  wire logic [OP_W-1:0]       s_tuser,
  input  wire logic                  m_tvalid,
  input  wire logic                  m_tready,
  input  wire logic [OUT_TDATA_W-1:0] m_tdata,
  input  wire logic [ST_W-1:0]       m_tuser,
  output int                         fail_count,
  output int                         pending
);

  localparam int  TERMS = DEF_MAX_TERMS;
  localparam longint Q_ONE = 64'sd16777216;

  typedef struct {
    logic [DATA_W-1:0] coef;
    logic [ST_W-1:0]   st;
  } coef_due_t;

  coef_due_t coef_due[$];

  int coef_a[TERMS];
  int coef_b[TERMS];
  int coef_q[TERMS];
  bit clamped;

  function automatic longint qmul(input longint x, input longint y);
    longint pr;
    longint unsigned m;
    pr = x * y;
    m = (pr < 0) ? longint'(-pr) : pr;
    m = (m + (64'd1 << 23)) >> 24;
    return (pr < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      clamped = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clamped = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint qdiv(input longint n, input longint d);
    longint unsigned mn, md, q;
    mn = (n < 0) ? longint'(-n) : n;
    md = (d < 0) ? longint'(-d) : d;
    q = (mn + md / 2) / md;
    return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint rd_a(input int idx);
    return (idx < TERMS) ? longint'(coef_a[idx]) : 0;
  endfunction

  function automatic longint rd_b(input int idx);
    return (idx < TERMS) ? longint'(coef_b[idx]) : 0;
  endfunction

  function automatic longint rd_q(input int idx);
    return (idx < TERMS) ? longint'(coef_q[idx]) : 0;
  endfunction

  task automatic compute_coef(input logic [OP_W-1:0] op, input int p, input longint val,
                              input longint za, input longint zb, input longint ga,
                              input longint gb, output bit has, output coef_due_t due);
    longint acc, num, r, k;
    int i;
    clamped = 1'b0;
    has = 1'b0;
    r = 0;
    due.st = ST_OK;
    case (op)
      OP_WR_A: if (p < TERMS) coef_a[p] = int'(val);
      OP_WR_B: if (p < TERMS) coef_b[p] = int'(val);
      OP_PRODUCT: begin
        has = 1'b1;
        acc = 0;
        for (i = 1; i < p; i++) acc += qmul(rd_a(i), rd_b(p - i));
        acc = qmul(gb, clamp32(qmul(ga, clamp32(acc))));
        acc += qmul(ga, clamp32(qmul(zb, rd_a(p))));
        acc += qmul(gb, clamp32(qmul(za, rd_b(p))));
        r = clamp32(acc);
      end
      OP_DIVIDE: begin
        has = 1'b1;
        acc = qmul(za, rd_b(p + 1)) + qmul(rd_b(1), rd_q(p));
        for (i = 1; i < p; i++) acc += qmul(rd_q(i), rd_b(p - i + 1));
        num = val - clamp32(acc);
        if (zb == 0) due.st = ST_DIV0;
        else begin
          r = clamp32(qdiv(num * Q_ONE, zb));
          if (p + 1 < TERMS) coef_q[p + 1] = int'(r);
        end
      end
      OP_POWER: begin
        has = 1'b1;
        acc = qmul(clamp32(qmul(val, rd_a(p))), zb);
        for (i = 1; i < p; i++) begin
          k = clamp32(qdiv((val + Q_ONE) * i, p) - Q_ONE);
          acc += qmul(k, clamp32(qmul(rd_a(i), rd_b(p - i))));
        end
        num = clamp32(acc);
        if (za == 0) due.st = ST_DIV0;
        else begin
          r = clamp32(qdiv(num * Q_ONE, za));
          coef_b[p] = int'(r);
        end
      end
      default: ;
    endcase
    if (due.st == ST_OK && clamped) due.st = ST_SAT;
    if (due.st == ST_DIV0) r = 0;
    due.coef = r[DATA_W-1:0];
  endtask

  assign pending = coef_due.size();

  always @(posedge clk) begin
    bit has;
    coef_due_t due, got;
    int errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        compute_coef(s_tuser, int'(s_tdata[5:0]),
                     longint'($signed(s_tdata[37:6])), longint'($signed(s_tdata[69:38])),
                     longint'($signed(s_tdata[101:70])), longint'($signed(s_tdata[133:102])),
                     longint'($signed(s_tdata[165:134])), has, due);
        if (has) coef_due.push_back(due);
      end
      if (m_tvalid && m_tready) begin
        if (coef_due.size() == 0) begin
          $error("result beat with nothing outstanding: result %h status %0d", m_tdata, m_tuser);
          errs++;
        end else begin
          got = coef_due.pop_front();
          if (m_tdata !== got.coef) begin
            $error("result: expected %h, actual %h", got.coef, m_tdata);
            errs++;
          end
          if (m_tuser !== got.st) begin
            $error("status: expected %0d, actual %0d", got.st, m_tuser);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

endmodule

@@ bench/power_series_coefficient_engine_core_test.sv @@
`timescale 1ns / 1ps
module power_series_coefficient_engine_core_test;
  import psce_pkg::*;

  localparam int TERMS = DEF_MAX_TERMS;
  localparam logic [31:0] Q1 = 32'h0100_0000;
  localparam logic [31:0] QM1 = 32'hFF00_0000;
  localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S_MIN = 32'h8000_0000;
  localparam logic [OP_W-1:0] OP_NONE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_NONE_HI = 3'd7;
  localparam int LIMIT = 1_500_000;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata;
  logic [OP_W-1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [ST_W-1:0] m_tuser;
  int fail_count;
  int pending;
  int cycles;
  int stall_left;
  bit calm;
  bit wa[TERMS];
  bit wb[TERMS];
  bit wq[TERMS];

  power_series_coefficient_engine_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  power_series_coefficient_checker i_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side back-pressure in bursts
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 15);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic logic [31:0] pick_val();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return S_MIN;
      2: return S_MAX;
      3: return Q1;
      default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return Q1;
      1: return QM1;
      2: return $urandom;
      default: return pick_val();
    endcase
  endfunction

  function automatic logic [31:0] pick_den();
    return ($urandom_range(0, 12) == 0) ? 32'h0 : pick_val();
  endfunction

  // every store entry the operation reads must have been written
  function automatic bit readable(input logic [OP_W-1:0] op, input int p);
    int i;
    case (op)
      OP_PRODUCT: begin
        if (p == 0) return wa[0] && wb[0];
        for (i = 1; i <= p; i++) if (!wa[i] || !wb[i]) return 1'b0;
        return 1'b1;
      end
      OP_DIVIDE: begin
        // term order zero reads quotient entry 0, which nothing ever stores
        if (p == 0) return 1'b0;
        for (i = 1; i <= p + 1 && i < TERMS; i++) if (!wb[i]) return 1'b0;
        for (i = 1; i <= p; i++) if (!wq[i]) return 1'b0;
        return 1'b1;
      end
      OP_POWER: begin
        if (!wa[p]) return 1'b0;
        for (i = 1; i < p; i++) if (!wa[i] || !wb[i]) return 1'b0;
        return 1'b1;
      end
      default: return 1'b1;
    endcase
  endfunction

  task automatic send_beat(input logic [OP_W-1:0] op, input int p, input logic [31:0] val,
                           input logic [31:0] za, input logic [31:0] zb,
                           input logic [31:0] ga, input logic [31:0] gb);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {2'b00, gb, ga, zb, za, val, p[5:0]};
    do @(posedge clk); while (!s_tready);
    case (op)
      OP_WR_A: wa[p] = 1'b1;
      OP_WR_B: wb[p] = 1'b1;
      OP_DIVIDE: if (zb != 0 && p + 1 < TERMS) wq[p + 1] = 1'b1;
      OP_POWER: if (za != 0) wb[p] = 1'b1;
      default: ;
    endcase
  endtask

  task automatic write_coef(input int p);
    send_beat($urandom_range(0, 1) ? OP_WR_A : OP_WR_B, p, pick_val(), $urandom, $urandom,
              $urandom, $urandom);
  endtask

  initial begin
    int k, p, r, i;
    logic [OP_W-1:0] op;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_WR_A;
    cycles = 0;
    calm = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_beat(OP_WR_A, 0, S_MAX, 0, 0, 0, 0);
    send_beat(OP_WR_B, 0, S_MIN, 0, 0, 0, 0);
    for (i = 1; i <= 4; i++) begin
      send_beat(OP_WR_A, i, (i == 4) ? S_MIN : Q1 >> i, 0, 0, 0, 0);
      send_beat(OP_WR_B, i, (i == 4) ? S_MAX : Q1 + (i << 20), 0, 0, 0, 0);
    end
    send_beat(OP_PRODUCT, 0, 0, Q1, Q1, Q1, Q1);
    send_beat(OP_PRODUCT, 3, 0, Q1, QM1, QM1, Q1);
    send_beat(OP_PRODUCT, 4, 0, S_MAX, S_MIN, S_MAX, S_MIN);
    send_beat(OP_POWER, 2, Q1 >> 1, 0, Q1, 0, 0);
    send_beat(OP_POWER, 3, Q1 >> 1, Q1, Q1, 0, 0);
    send_beat(OP_NONE_LO, 2, $urandom, $urandom, $urandom, $urandom, $urandom);
    send_beat(OP_NONE_HI, 63, $urandom, $urandom, $urandom, $urandom, $urandom);
    send_beat(OP_WR_B, 63, S_MAX, 0, 0, 0, 0);

    for (k = 0; k < 1030; k++) begin
      calm = (k >= 930);
      if (k == 500) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      p = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, TERMS - 1);
      if (r < 3) begin
        send_beat($urandom_range(OP_NONE_LO, OP_NONE_HI), p, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
      end else if (r < 30) begin
        write_coef(p);
      end else begin
        op = $urandom_range(OP_PRODUCT, OP_POWER);
        if (!readable(op, p)) write_coef(p);
        else if (op == OP_PRODUCT)
          send_beat(op, p, $urandom, pick_val(), pick_val(), pick_gain(), pick_gain());
        else if (op == OP_DIVIDE)
          send_beat(op, p, pick_val(), pick_val(), pick_den(), $urandom, $urandom);
        else
          send_beat(op, p, pick_val(), pick_den(), pick_val(), $urandom, $urandom);
      end
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
